FILE: rtl/wcu_pkg.sv
// shared types and constants for the waveform chunk unpacker
`default_nettype none

package wcu_pkg;

    // record limits
    localparam int MAX_SAMPLES = 2048;
    localparam int MAX_RUN     = 64;

    // counter widths
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int RUN_W = $clog2(MAX_RUN + 1);

    // width code layout
    localparam int MAX_WIDTH  = 16;
    localparam int DELTA_BASE = 32;

    // final status codes
    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_SHORT    = 3'd1;
    localparam logic [2:0] STATUS_BAD_CODE = 3'd2;
    localparam logic [2:0] STATUS_LONG_RUN = 3'd3;
    localparam logic [2:0] STATUS_CLIPPED  = 3'd4;

    // input word
    typedef struct packed {
        logic [15:0] word;
        logic        record_end;
    } wcu_in_t;

    // result word
    typedef struct packed {
        logic signed [15:0] sample;
        logic               sample_valid;
        logic               run_last;
        logic               record_done;
        logic [2:0]         status;
    } wcu_out_t;

endpackage

`default_nettype wire

FILE: rtl/waveform_chunk_unpacker.sv
// top level of the waveform chunk unpacker
//
// Usage: feed the 16-bit words of a compressed record on the s_ channel,
// record_end set on its final word. Decoded samples leave on the m_ channel,
// one word per sample; a record that ends without a sample on its last input
// word gives one word with sample_valid low that carries record_done.
// run_last marks the last word caused by an input word, record_done the word
// that finishes the record, and status holds the final code there.
// Timing: an input word is registered and then decoded in the EXEC state once
// the output register is free; a start sample is written to the output
// register by that decode step, each sample of a zero-width run or of packed
// fields by the ZRUN or DLOOP state through the shared adder, packed fields
// also through the field shifter (runs up to MAX_RUN, packed words up to 16).
// s_ready is high only while the sequencer is idle; the last result may
// still sit in the output register while the next word is taken.
// Stall: when m_ready is low the sequencer holds its current sample until the
// output register frees up, so nothing is dropped.
// Reset: aresetn (synchronous, active low) clears the sequencer and the
// output valid flag; the next word is read as a length word.
`default_nettype none

module waveform_chunk_unpacker
    import wcu_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire wcu_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output wcu_out_t      m_data
);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_ZRUN  = 2'd2;
    localparam logic [1:0] ST_DLOOP = 2'd3;

    // record phases
    localparam logic [2:0] PH_LENGTH = 3'd0;
    localparam logic [2:0] PH_COUNT  = 3'd1;
    localparam logic [2:0] PH_CODE   = 3'd2;
    localparam logic [2:0] PH_START  = 3'd3;
    localparam logic [2:0] PH_OFFSET = 3'd4;
    localparam logic [2:0] PH_DATA   = 3'd5;
    localparam logic [2:0] PH_DRAIN  = 3'd6;

    logic [1:0]       st_reg, st_next;
    logic [2:0]       phase_reg, phase_next;
    logic [CNT_W-1:0] declared_length_reg, declared_length_next;
    logic [CNT_W-1:0] samples_done_reg, samples_done_next;
    logic [15:0]      chunk_left_reg, chunk_left_next;
    logic [4:0]       field_width_reg, field_width_next;
    logic             delta_mode_reg, delta_mode_next;
    logic [15:0]      offset_value_reg, offset_value_next;
    logic [15:0]      previous_sample_reg, previous_sample_next;
    logic [31:0]      bit_buffer_reg, bit_buffer_next;
    logic [5:0]       bits_held_reg, bits_held_next;
    logic [2:0]       error_code_reg, error_code_next;
    logic [RUN_W-1:0] run_cnt_reg, run_cnt_next;
    logic [15:0]      word_reg, word_next;
    logic             end_reg, end_next;
    logic             m_valid_reg, m_valid_next;
    wcu_out_t         m_data_reg, m_data_next;

    logic             out_free;
    logic [15:0]      field;
    logic [15:0]      add_a;
    logic [15:0]      add_sum;
    logic [CNT_W-1:0] done_inc;
    logic             hit;
    logic [CNT_W-1:0] due;
    logic [15:0]      run_full;
    logic [5:0]       held_sub;
    logic [5:0]       held_add;
    logic [15:0]      chunk_dec;

    assign s_ready  = (st_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // field shifter
    wcu_field_extract u_extract (
        .bit_buffer  (bit_buffer_reg),
        .bits_held   (bits_held_reg),
        .field_width (field_width_reg),
        .field       (field)
    );

    // shared sample adder and count compare
    assign add_a    = (st_reg == ST_DLOOP) ? field : 16'd0;
    assign add_sum  = add_a + offset_value_reg + (delta_mode_reg ? previous_sample_reg : 16'd0);
    assign done_inc = samples_done_reg + 1'b1;
    assign hit      = (done_inc >= declared_length_reg);
    assign due      = declared_length_reg - samples_done_reg;
    assign run_full = (chunk_left_reg < 16'(due)) ? chunk_left_reg : 16'(due);
    assign held_sub = bits_held_reg - {1'b0, field_width_reg};
    assign held_add = bits_held_reg + 6'd16;
    assign chunk_dec = chunk_left_reg - 16'd1;

    // sequencer
    always_comb begin
        logic        emit;
        logic [15:0] emit_v;
        logic        emit_last;
        logic        fin;
        logic        quiet;
        logic [2:0]  fin_status;

        st_next              = st_reg;
        phase_next           = phase_reg;
        declared_length_next = declared_length_reg;
        samples_done_next    = samples_done_reg;
        chunk_left_next      = chunk_left_reg;
        field_width_next     = field_width_reg;
        delta_mode_next      = delta_mode_reg;
        offset_value_next    = offset_value_reg;
        previous_sample_next = previous_sample_reg;
        bit_buffer_next      = bit_buffer_reg;
        bits_held_next       = bits_held_reg;
        error_code_next      = error_code_reg;
        run_cnt_next         = run_cnt_reg;
        word_next            = word_reg;
        end_next             = end_reg;
        m_valid_next         = m_valid_reg && !m_ready;
        m_data_next          = m_data_reg;

        emit       = 1'b0;
        emit_v     = 16'd0;
        emit_last  = 1'b0;
        fin        = 1'b0;
        quiet      = 1'b0;
        fin_status = error_code_reg;

        case (st_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    word_next = s_data.word;
                    end_next  = s_data.record_end;
                    st_next   = ST_EXEC;
                end
            end

            ST_EXEC: begin
                if (out_free) begin
                    st_next = ST_IDLE;
                    case (phase_reg)
                        PH_LENGTH: begin
                            samples_done_next    = '0;
                            chunk_left_next      = '0;
                            field_width_next     = '0;
                            delta_mode_next      = 1'b0;
                            offset_value_next    = '0;
                            previous_sample_next = '0;
                            bit_buffer_next      = '0;
                            bits_held_next       = '0;
                            error_code_next      = STATUS_OK;
                            if (word_reg == 16'd0 || word_reg[15]) begin
                                declared_length_next = '0;
                                fin = 1'b1;
                            end else begin
                                if (word_reg > 16'(MAX_SAMPLES)) begin
                                    declared_length_next = CNT_W'(MAX_SAMPLES);
                                    error_code_next      = STATUS_CLIPPED;
                                end else begin
                                    declared_length_next = word_reg[CNT_W-1:0];
                                end
                                phase_next = PH_COUNT;
                            end
                        end
                        PH_COUNT: begin
                            chunk_left_next = word_reg;
                            phase_next      = PH_CODE;
                        end
                        PH_CODE: begin
                            if (word_reg <= 16'(MAX_WIDTH)) begin
                                delta_mode_next  = 1'b0;
                                field_width_next = word_reg[4:0];
                                phase_next       = PH_OFFSET;
                            end else if (word_reg inside
                                         {[DELTA_BASE:DELTA_BASE + MAX_WIDTH]}) begin
                                delta_mode_next  = 1'b1;
                                field_width_next = 5'(word_reg - 16'(DELTA_BASE));
                                phase_next       = PH_START;
                            end else begin
                                error_code_next = STATUS_BAD_CODE;
                                fin = 1'b1;
                            end
                        end
                        PH_START: begin
                            emit      = 1'b1;
                            emit_v    = word_reg;
                            emit_last = 1'b1;
                            if (!hit) begin
                                if (chunk_left_reg != 16'd0) begin
                                    chunk_left_next = chunk_dec;
                                end
                                phase_next = PH_OFFSET;
                            end
                        end
                        PH_OFFSET: begin
                            offset_value_next = word_reg;
                            if (chunk_left_reg == 16'd0) begin
                                phase_next = PH_COUNT;
                            end else if (field_width_reg == 5'd0) begin
                                if (run_full > 16'(MAX_RUN)) begin
                                    error_code_next = STATUS_LONG_RUN;
                                    fin = 1'b1;
                                end else begin
                                    run_cnt_next = run_full[RUN_W-1:0];
                                    st_next      = ST_ZRUN;
                                end
                            end else begin
                                bit_buffer_next = '0;
                                bits_held_next  = '0;
                                phase_next      = PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            bit_buffer_next = {bit_buffer_reg[15:0], word_reg};
                            bits_held_next  = held_add;
                            if (held_add >= {1'b0, field_width_reg}) begin
                                st_next = ST_DLOOP;
                            end
                        end
                        default: begin
                            // trailing words after the record is done
                            quiet = 1'b1;
                            if (end_reg) begin
                                phase_next = PH_LENGTH;
                            end
                        end
                    endcase

                    // finish without a sample on this word
                    if (!emit && !quiet && st_next == ST_IDLE && (fin || end_reg)) begin
                        fin_status      = fin ? error_code_next : STATUS_SHORT;
                        error_code_next = fin_status;
                        m_valid_next    = 1'b1;
                        m_data_next.sample       = '0;
                        m_data_next.sample_valid = 1'b0;
                        m_data_next.run_last     = 1'b1;
                        m_data_next.record_done  = 1'b1;
                        m_data_next.status       = fin_status;
                        phase_next = end_reg ? PH_LENGTH : PH_DRAIN;
                    end
                end
            end

            ST_ZRUN: begin
                if (out_free) begin
                    emit         = 1'b1;
                    emit_v       = add_sum;
                    emit_last    = (run_cnt_reg == RUN_W'(1)) || hit;
                    run_cnt_next = run_cnt_reg - 1'b1;
                    if (emit_last) begin
                        chunk_left_next = '0;
                        phase_next      = PH_COUNT;
                        st_next         = ST_IDLE;
                    end
                end
            end

            default: begin
                // packed fields, one per cycle while the output register is free
                if (out_free) begin
                    emit            = 1'b1;
                    emit_v          = add_sum;
                    bits_held_next  = held_sub;
                    chunk_left_next = chunk_dec;
                    emit_last = hit || (chunk_dec == 16'd0) ||
                                (held_sub < {1'b0, field_width_reg});
                    if (emit_last) begin
                        st_next = ST_IDLE;
                        if (!hit && chunk_dec == 16'd0) begin
                            bit_buffer_next = '0;
                            bits_held_next  = '0;
                            phase_next      = PH_COUNT;
                        end
                    end
                end
            end
        endcase

        // common sample emission
        if (emit) begin
            samples_done_next    = done_inc;
            previous_sample_next = emit_v;
            m_valid_next         = 1'b1;
            m_data_next.sample       = emit_v;
            m_data_next.sample_valid = 1'b1;
            m_data_next.run_last     = emit_last;
            m_data_next.record_done  = 1'b0;
            m_data_next.status       = error_code_reg;
            if (emit_last && (hit || end_reg)) begin
                fin_status      = hit ? error_code_reg : STATUS_SHORT;
                error_code_next = fin_status;
                m_data_next.record_done = 1'b1;
                m_data_next.status      = fin_status;
                phase_next = end_reg ? PH_LENGTH : PH_DRAIN;
            end
        end
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg              <= ST_IDLE;
            phase_reg           <= PH_LENGTH;
            declared_length_reg <= '0;
            samples_done_reg    <= '0;
            chunk_left_reg      <= '0;
            field_width_reg     <= '0;
            delta_mode_reg      <= 1'b0;
            offset_value_reg    <= '0;
            previous_sample_reg <= '0;
            bit_buffer_reg      <= '0;
            bits_held_reg       <= '0;
            error_code_reg      <= STATUS_OK;
            run_cnt_reg         <= '0;
            m_valid_reg         <= 1'b0;
        end else begin
            st_reg              <= st_next;
            phase_reg           <= phase_next;
            declared_length_reg <= declared_length_next;
            samples_done_reg    <= samples_done_next;
            chunk_left_reg      <= chunk_left_next;
            field_width_reg     <= field_width_next;
            delta_mode_reg      <= delta_mode_next;
            offset_value_reg    <= offset_value_next;
            previous_sample_reg <= previous_sample_next;
            bit_buffer_reg      <= bit_buffer_next;
            bits_held_reg       <= bits_held_next;
            error_code_reg      <= error_code_next;
            run_cnt_reg         <= run_cnt_next;
            m_valid_reg         <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        word_reg   <= word_next;
        end_reg    <= end_next;
        m_data_reg <= m_data_next;
    end

    // checks
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a word is still decoding");

    a_empty_is_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.sample_valid |-> m_data.record_done)
        else $error("result without a sample does not finish the record");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.record_done |-> m_data.run_last)
        else $error("record finished on a word that is not the last of its input");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        samples_done_reg <= declared_length_reg || phase_reg == PH_LENGTH)
        else $error("more samples than the declared length");

endmodule

`default_nettype wire

FILE: rtl/wcu_field_extract.sv
// picks the next msb-first field out of the bit buffer
`default_nettype none

module wcu_field_extract
    import wcu_pkg::*;
(
    input  wire logic [31:0] bit_buffer,
    input  wire logic [5:0]  bits_held,
    input  wire logic [4:0]  field_width,
    output logic      [15:0] field
);

    logic [5:0]  shift_amt;
    logic [31:0] shifted;
    logic [16:0] mask;

    // align the field to bit zero and keep its width
    assign shift_amt = bits_held - {1'b0, field_width};
    assign shifted   = bit_buffer >> shift_amt;
    assign mask      = (17'd1 << field_width) - 17'd1;
    assign field     = shifted[15:0] & mask[15:0];

endmodule

`default_nettype wire
